@@ design/gvi_pkg.sv @@
`timescale 1ns / 1ps

package gvi_pkg;

   localparam int RADIUS_CELLS_DEFAULT = 16;
   localparam int THETA_CELLS_DEFAULT  = 16;
   localparam int PHI_CELLS_DEFAULT    = 16;
   localparam int ACTION_COUNT         = 7;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_SWAP   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] REG_MOVE_REWARD = 2'd0;
   localparam logic [1:0] REG_DISCOUNT    = 2'd1;
   localparam logic [1:0] REG_ERROR_PROB  = 2'd2;

   localparam logic [2:0] ACT_STAY        = 3'd0;
   localparam logic [2:0] ACT_R_PLUS      = 3'd1;
   localparam logic [2:0] ACT_R_MINUS     = 3'd2;
   localparam logic [2:0] ACT_THETA_PLUS  = 3'd3;
   localparam logic [2:0] ACT_THETA_MINUS = 3'd4;
   localparam logic [2:0] ACT_PHI_PLUS    = 3'd5;
   localparam logic [2:0] ACT_PHI_MINUS   = 3'd6;

   // Offset that makes the dividend of the divide by six non-negative; it is
   // six times two to the 33rd, so the quotient is shifted by two to the 33rd.
   localparam logic [39:0] DIV_OFFSET   = 40'd51539607552;
   localparam logic [40:0] DIV_OFFSET_Q = 41'd8589934592;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COLLECT,
      ST_FEED,
      ST_DRAIN,
      ST_COMMIT,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] action;
   } pipe_tag_type;

   // One radix-16 digit of a division by six: returns {quotient digit, remainder}.
   function automatic logic [6:0] div6_step(input logic [2:0] rem, input logic [3:0] digit);
      logic [6:0]  t;
      logic [12:0] scaled;
      logic [3:0]  q;
      logic [6:0]  r;
      t      = {rem, digit};
      scaled = 13'(t) * 13'd43;
      q      = scaled[11:8];
      r      = t - ((7'(q) << 2) + (7'(q) << 1));
      return {q, r[2:0]};
   endfunction

endpackage

@@ design/gvi_ram.sv @@
`timescale 1ns / 1ps

module gvi_ram #(
   parameter int WIDTH      = 32,
   parameter int ADDR_WIDTH = 12
) (
   input  logic                  clock,
   input  logic                  write_enable,
   input  logic [ADDR_WIDTH-1:0] write_address,
   input  logic [WIDTH-1:0]      write_data,
   input  logic [ADDR_WIDTH-1:0] read_address,
   output logic [WIDTH-1:0]      read_data
);

   logic [WIDTH-1:0] mem [2**ADDR_WIDTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= mem[read_address];
   end

   assign read_data = read_data_ff;

endmodule

@@ design/gvi_action_pipe.sv @@
`timescale 1ns / 1ps

module gvi_action_pipe (
   input  logic                clock,
   input  logic                reset,
   input  gvi_pkg::pipe_tag_type in_tag,
   input  logic signed [31:0]  in_value,
   input  logic signed [34:0]  in_sum,
   input  logic [15:0]         error_prob,
   input  logic [15:0]         discount,
   input  logic signed [31:0]  move_reward,
   output gvi_pkg::pipe_tag_type out_tag,
   output logic signed [31:0]  out_total
);

   localparam logic signed [48:0] SAT_MAX = 49'sd2147483647;
   localparam logic signed [48:0] SAT_MIN = -49'sd2147483648;

   gvi_pkg::pipe_tag_type tag_ff [1:6];

   logic signed [31:0] value1_ff, value2_ff, value3_ff;
   logic signed [35:0] diff1_ff, diff1_in;
   logic signed [52:0] prod2_ff, prod2_in;
   logic [19:0]        qhi3_ff, qhi3_in;
   logic [2:0]         rem3_ff, rem3_in;
   logic [19:0]        ulo3_ff, ulo3_in;
   logic signed [31:0] e4_ff, e4_in;
   logic signed [48:0] prod5_ff, prod5_in;
   logic signed [31:0] tot6_ff, tot6_in;

   always_comb begin
      diff1_in = 36'(in_sum) - ((36'(in_value) <<< 3) - 36'(in_value));
      prod2_in = 53'(diff1_ff) * 53'($signed({1'b0, error_prob}));
   end

   always_comb begin
      logic signed [52:0] y;
      logic [52:0]        u_full;
      logic [39:0]        u;
      logic [2:0]         rem;
      logic [6:0]         step;
      y      = prod2_ff >>> 16;
      u_full = y + 53'(gvi_pkg::DIV_OFFSET);
      u      = u_full[39:0];
      rem    = 3'd0;
      qhi3_in = '0;
      for (int k = 0; k < 5; k++) begin
         step = gvi_pkg::div6_step(rem, u[39-4*k -: 4]);
         qhi3_in[19-4*k -: 4] = step[6:3];
         rem = step[2:0];
      end
      rem3_in = rem;
      ulo3_in = u[19:0];
   end

   always_comb begin
      logic [2:0]         rem;
      logic [6:0]         step;
      logic [19:0]        qlo;
      logic signed [40:0] qv;
      logic signed [40:0] e;
      rem = rem3_ff;
      qlo = '0;
      for (int k = 0; k < 5; k++) begin
         step = gvi_pkg::div6_step(rem, ulo3_ff[19-4*k -: 4]);
         qlo[19-4*k -: 4] = step[6:3];
         rem = step[2:0];
      end
      qv    = $signed({1'b0, qhi3_ff, qlo}) - $signed(gvi_pkg::DIV_OFFSET_Q);
      e     = 41'(value3_ff) + qv;
      e4_in = e[31:0];
   end

   always_comb begin
      logic signed [48:0] d;
      logic signed [48:0] tot;
      prod5_in = 49'(e4_ff) * 49'($signed({1'b0, discount}));
      d        = prod5_ff >>> 16;
      tot      = 49'(move_reward) + d;
      if (tot > SAT_MAX) begin
         tot6_in = 32'sh7FFFFFFF;
      end else if (tot < SAT_MIN) begin
         tot6_in = 32'sh80000000;
      end else begin
         tot6_in = tot[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 6; k++) begin
            tag_ff[k] <= '0;
         end
      end else begin
         tag_ff[1] <= in_tag;
         for (int k = 2; k <= 6; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      value1_ff <= in_value;
      diff1_ff  <= diff1_in;
      value2_ff <= value1_ff;
      prod2_ff  <= prod2_in;
      value3_ff <= value2_ff;
      qhi3_ff   <= qhi3_in;
      rem3_ff   <= rem3_in;
      ulo3_ff   <= ulo3_in;
      e4_ff     <= e4_in;
      prod5_ff  <= prod5_in;
      tot6_ff   <= tot6_in;
   end

   assign out_tag   = tag_ff[6];
   assign out_total = tot6_ff;

endmodule

@@ design/grid_value_iteration_cell.sv @@
`timescale 1ns / 1ps

// Write, swap and unused commands answer with one result strobe in the cycle after the
// transaction is accepted. An update of an ordinary cell runs from acceptance to its result
// strobe through seven neighbor reads over the single read port of the previous value
// bank, then the seven actions pass one per cycle through a six-stage arithmetic pipeline,
// then the write-back. An update of an obstacle or goal cell makes the same reads, skips
// the pipeline and writes its old value back. Busy stays high until the result cycle is
// over, and the result is shown for that single cycle only, since it cannot be held off.
module grid_value_iteration_cell #(
   parameter int RADIUS_CELLS = gvi_pkg::RADIUS_CELLS_DEFAULT,
   parameter int THETA_CELLS  = gvi_pkg::THETA_CELLS_DEFAULT,
   parameter int PHI_CELLS    = gvi_pkg::PHI_CELLS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [3:0]         req_r_index,
   input  logic [3:0]         req_theta_index,
   input  logic [3:0]         req_phi_index,
   input  logic signed [31:0] req_cell_value,
   input  logic               req_is_obstacle,
   input  logic               req_is_goal,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_new_value,
   output logic [2:0]         rsp_best_action,
   output logic               rsp_updated,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   localparam int RW = $clog2(RADIUS_CELLS);
   localparam int TW = $clog2(THETA_CELLS);
   localparam int PW = $clog2(PHI_CELLS);
   localparam int AW = RW + TW + PW;

   gvi_pkg::state_type state_ff, state_in;

   logic signed [31:0] move_reward_ff;
   logic [15:0]        discount_ff;
   logic [15:0]        error_prob_ff;
   logic               bank_sel_ff;

   logic [RW-1:0] r_ff;
   logic [TW-1:0] t_ff;
   logic [PW-1:0] p_ff;
   logic [2:0]    count_ff;
   logic          rd_valid_ff;
   logic [2:0]    rd_slot_ff;
   logic signed [31:0] nb_ff [7];
   logic signed [34:0] sum_ff;
   logic [1:0]         marks_ff;
   logic signed [31:0] best_ff;
   logic [2:0]         best_action_ff;
   logic signed [31:0] result_value_ff;
   logic [2:0]         result_action_ff;
   logic               result_updated_ff;

   logic [8:0]    r_ext, t_ext, p_ext;
   logic [RW-1:0] req_r;
   logic [TW-1:0] req_t;
   logic [PW-1:0] req_p;
   logic          in_grid;
   logic          accept;
   logic          cell_write;
   logic          next_write;
   logic          marked;
   logic [AW-1:0] own_addr;
   logic [AW-1:0] req_addr;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic signed [31:0] wr_value;
   logic signed [31:0] next_value;
   logic [31:0]   rdata_a, rdata_b;
   logic [1:0]    rdata_marks;
   logic signed [31:0] prev_rdata;
   logic [RW-1:0] rp, rm;
   logic [TW-1:0] tp, tm;
   logic [PW-1:0] pp, pm;

   gvi_pkg::pipe_tag_type pipe_in_tag, pipe_out_tag;
   logic signed [31:0]    pipe_out_total;

   always_comb begin
      r_ext  = {5'd0, req_r_index};
      t_ext  = {5'd0, req_theta_index};
      p_ext  = {5'd0, req_phi_index};
      req_r  = r_ext[RW-1:0];
      req_t  = t_ext[TW-1:0];
      req_p  = p_ext[PW-1:0];
      in_grid = (r_ext < 9'(RADIUS_CELLS)) && (t_ext < 9'(THETA_CELLS))
                && (p_ext < 9'(PHI_CELLS));
      req_addr = {req_p, req_r, req_t};
      own_addr = {p_ff, r_ff, t_ff};
      rp = (r_ff == RW'(RADIUS_CELLS - 1)) ? r_ff : r_ff + RW'(1);
      rm = (r_ff == '0) ? r_ff : r_ff - RW'(1);
      tp = (t_ff == TW'(THETA_CELLS - 1)) ? '0 : t_ff + TW'(1);
      tm = (t_ff == '0) ? TW'(THETA_CELLS - 1) : t_ff - TW'(1);
      pp = (p_ff == PW'(PHI_CELLS - 1)) ? '0 : p_ff + PW'(1);
      pm = (p_ff == '0) ? PW'(PHI_CELLS - 1) : p_ff - PW'(1);
      prev_rdata = bank_sel_ff ? $signed(rdata_b) : $signed(rdata_a);
      marked = |marks_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gvi_pkg::ST_IDLE: begin
            if (start) begin
               if (req_command == gvi_pkg::CMD_UPDATE && in_grid) begin
                  state_in = gvi_pkg::ST_READ;
               end else begin
                  state_in = gvi_pkg::ST_RESPOND;
               end
            end
         end
         gvi_pkg::ST_READ: begin
            if (count_ff == gvi_pkg::ACT_PHI_MINUS) begin
               state_in = gvi_pkg::ST_COLLECT;
            end
         end
         gvi_pkg::ST_COLLECT: begin
            state_in = gvi_pkg::ST_FEED;
         end
         gvi_pkg::ST_FEED: begin
            if (marked) begin
               state_in = gvi_pkg::ST_RESPOND;
            end else if (count_ff == gvi_pkg::ACT_PHI_MINUS) begin
               state_in = gvi_pkg::ST_DRAIN;
            end
         end
         gvi_pkg::ST_DRAIN: begin
            if (pipe_out_tag.valid && pipe_out_tag.action == gvi_pkg::ACT_PHI_MINUS) begin
               state_in = gvi_pkg::ST_COMMIT;
            end
         end
         gvi_pkg::ST_COMMIT: begin
            state_in = gvi_pkg::ST_RESPOND;
         end
         gvi_pkg::ST_RESPOND: begin
            state_in = gvi_pkg::ST_IDLE;
         end
         default: begin
            state_in = gvi_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      accept      = (state_ff == gvi_pkg::ST_IDLE) && start;
      cell_write  = accept && req_command == gvi_pkg::CMD_WRITE && in_grid;
      next_write  = (state_ff == gvi_pkg::ST_FEED && marked)
                    || state_ff == gvi_pkg::ST_COMMIT;
      next_value  = (state_ff == gvi_pkg::ST_COMMIT) ? best_ff : nb_ff[0];
      wr_value    = cell_write ? req_cell_value : next_value;
      wr_addr     = cell_write ? req_addr : own_addr;
      pipe_in_tag.valid  = state_ff == gvi_pkg::ST_FEED && !marked;
      pipe_in_tag.action = count_ff;
      busy        = state_ff != gvi_pkg::ST_IDLE;
      rsp_strobe  = state_ff == gvi_pkg::ST_RESPOND;
      case (count_ff)
         gvi_pkg::ACT_R_PLUS:      rd_addr = {p_ff, rp, t_ff};
         gvi_pkg::ACT_R_MINUS:     rd_addr = {p_ff, rm, t_ff};
         gvi_pkg::ACT_THETA_PLUS:  rd_addr = {p_ff, r_ff, tp};
         gvi_pkg::ACT_THETA_MINUS: rd_addr = {p_ff, r_ff, tm};
         gvi_pkg::ACT_PHI_PLUS:    rd_addr = {pp, r_ff, t_ff};
         gvi_pkg::ACT_PHI_MINUS:   rd_addr = {pm, r_ff, t_ff};
         default:                  rd_addr = own_addr;
      endcase
   end

   gvi_ram #(.WIDTH(32), .ADDR_WIDTH(AW)) u_bank_a (
      .clock         (clock),
      .write_enable  (cell_write || (next_write && bank_sel_ff)),
      .write_address (wr_addr),
      .write_data    (wr_value),
      .read_address  (rd_addr),
      .read_data     (rdata_a)
   );

   gvi_ram #(.WIDTH(32), .ADDR_WIDTH(AW)) u_bank_b (
      .clock         (clock),
      .write_enable  (cell_write || (next_write && !bank_sel_ff)),
      .write_address (wr_addr),
      .write_data    (wr_value),
      .read_address  (rd_addr),
      .read_data     (rdata_b)
   );

   gvi_ram #(.WIDTH(2), .ADDR_WIDTH(AW)) u_marks (
      .clock         (clock),
      .write_enable  (cell_write),
      .write_address (req_addr),
      .write_data    ({req_is_goal, req_is_obstacle}),
      .read_address  (rd_addr),
      .read_data     (rdata_marks)
   );

   gvi_action_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .in_tag      (pipe_in_tag),
      .in_value    (nb_ff[count_ff]),
      .in_sum      (sum_ff),
      .error_prob  (error_prob_ff),
      .discount    (discount_ff),
      .move_reward (move_reward_ff),
      .out_tag     (pipe_out_tag),
      .out_total   (pipe_out_total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gvi_pkg::ST_IDLE;
         count_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         bank_sel_ff    <= 1'b0;
         move_reward_ff <= '0;
         discount_ff    <= 16'hFFFF;
         error_prob_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= state_ff == gvi_pkg::ST_READ;
         if (state_ff == gvi_pkg::ST_READ || (state_ff == gvi_pkg::ST_FEED && !marked)) begin
            count_ff <= (count_ff == gvi_pkg::ACT_PHI_MINUS) ? 3'd0 : count_ff + 3'd1;
         end else begin
            count_ff <= '0;
         end
         if (accept && req_command == gvi_pkg::CMD_SWAP) begin
            bank_sel_ff <= !bank_sel_ff;
         end
         if (csr_write_enable) begin
            case (csr_index)
               gvi_pkg::REG_MOVE_REWARD: move_reward_ff <= csr_write_data;
               gvi_pkg::REG_DISCOUNT:    discount_ff    <= csr_write_data[15:0];
               gvi_pkg::REG_ERROR_PROB:  error_prob_ff  <= csr_write_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff <= count_ff;
      if (accept) begin
         r_ff              <= req_r;
         t_ff              <= req_t;
         p_ff              <= req_p;
         result_value_ff   <= '0;
         result_action_ff  <= gvi_pkg::ACT_STAY;
         result_updated_ff <= 1'b0;
      end
      if (rd_valid_ff) begin
         nb_ff[rd_slot_ff] <= prev_rdata;
         if (rd_slot_ff == gvi_pkg::ACT_STAY) begin
            sum_ff   <= 35'(prev_rdata);
            marks_ff <= rdata_marks;
         end else begin
            sum_ff <= sum_ff + 35'(prev_rdata);
         end
      end
      if (pipe_out_tag.valid) begin
         if (pipe_out_tag.action == gvi_pkg::ACT_STAY || pipe_out_total > best_ff) begin
            best_ff        <= pipe_out_total;
            best_action_ff <= pipe_out_tag.action;
         end
      end
      if (state_ff == gvi_pkg::ST_FEED && marked) begin
         result_value_ff <= nb_ff[0];
      end
      if (state_ff == gvi_pkg::ST_COMMIT) begin
         result_value_ff   <= best_ff;
         result_action_ff  <= best_action_ff;
         result_updated_ff <= 1'b1;
      end
   end

   assign rsp_new_value   = result_value_ff;
   assign rsp_best_action = result_action_ff;
   assign rsp_updated     = result_updated_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted transaction did not raise busy.");

   a_pipe_window: assert property (@(posedge clock) disable iff (reset)
      pipe_out_tag.valid |-> (state_ff == gvi_pkg::ST_FEED || state_ff == gvi_pkg::ST_DRAIN))
      else $error("Pipeline result outside the evaluation window.");

   a_updated_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_updated) |-> (rsp_best_action <= gvi_pkg::ACT_PHI_MINUS))
      else $error("Updated result with an invalid action.");

   a_respond_once: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe lasted more than one cycle.");

endmodule

@@ sim/tb_grid_value_iteration_cell.sv @@
`timescale 1ns / 1ps

module tb_grid_value_iteration_cell;

   localparam int GRID_CELLS = 4096;
   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_command;
   logic [3:0]         req_r_index;
   logic [3:0]         req_theta_index;
   logic [3:0]         req_phi_index;
   logic signed [31:0] req_cell_value;
   logic               req_is_obstacle;
   logic               req_is_goal;
   logic               rsp_strobe;
   logic signed [31:0] rsp_new_value;
   logic [2:0]         rsp_best_action;
   logic               rsp_updated;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [31:0]        csr_write_data;

   typedef struct packed {
      logic signed [31:0] value;
      logic [2:0]         action;
      logic               updated;
   } cell_answer_type;

   logic [31:0]        plan_bank_a [GRID_CELLS];
   logic [31:0]        plan_bank_b [GRID_CELLS];
   logic               plan_obstacle [GRID_CELLS];
   logic               plan_goal [GRID_CELLS];
   logic               plan_written [GRID_CELLS];
   logic               plan_bank_sel;
   logic signed [31:0] plan_reward;
   logic [15:0]        plan_discount;
   logic [15:0]        plan_error_prob;

   cell_answer_type answer_queue[$];
   int  error_count;
   int  idle_cycles;
   int  sent_count;
   int  update_count;
   bit  idling_enabled;

   grid_value_iteration_cell u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_r_index(req_r_index),
      .req_theta_index(req_theta_index), .req_phi_index(req_phi_index),
      .req_cell_value(req_cell_value), .req_is_obstacle(req_is_obstacle),
      .req_is_goal(req_is_goal), .rsp_strobe(rsp_strobe),
      .rsp_new_value(rsp_new_value), .rsp_best_action(rsp_best_action),
      .rsp_updated(rsp_updated), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int cell_index(input int r, input int t, input int p);
      return (p * 16 + r) * 16 + t;
   endfunction

   function automatic longint read_previous(input int a);
      return plan_bank_sel ? longint'(signed'(plan_bank_b[a]))
                           : longint'(signed'(plan_bank_a[a]));
   endfunction

   function automatic void write_next(input int a, input logic [31:0] v);
      if (plan_bank_sel) plan_bank_a[a] = v;
      else plan_bank_b[a] = v;
   endfunction

   function automatic longint floor_divide(input longint n, input longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic cell_answer_type iterate_cell(input logic [1:0] cmd, input int r,
         input int t, input int p, input logic [31:0] value, input logic obs,
         input logic goal);
      cell_answer_type ans;
      longint nb [7];
      longint sum, others, w, e, d, tot, best;
      int a;
      ans = '0;
      a = cell_index(r, t, p);
      if (cmd == gvi_pkg::CMD_WRITE) begin
         plan_bank_a[a] = value;
         plan_bank_b[a] = value;
         plan_obstacle[a] = obs;
         plan_goal[a] = goal;
         plan_written[a] = 1'b1;
      end else if (cmd == gvi_pkg::CMD_UPDATE) begin
         if (plan_obstacle[a] || plan_goal[a]) begin
            ans.value = 32'(read_previous(a));
            write_next(a, ans.value);
         end else begin
            nb[0] = read_previous(a);
            nb[1] = read_previous(cell_index(r < 15 ? r + 1 : r, t, p));
            nb[2] = read_previous(cell_index(r > 0 ? r - 1 : r, t, p));
            nb[3] = read_previous(cell_index(r, (t + 1) % 16, p));
            nb[4] = read_previous(cell_index(r, (t + 15) % 16, p));
            nb[5] = read_previous(cell_index(r, t, (p + 1) % 16));
            nb[6] = read_previous(cell_index(r, t, (p + 15) % 16));
            sum = 0;
            best = 0;
            foreach (nb[n]) sum += nb[n];
            for (int n = 0; n < 7; n++) begin
               others = sum - nb[n];
               w = (65536 - longint'(plan_error_prob)) * 6 * nb[n]
                   + longint'(plan_error_prob) * others;
               e = floor_divide(w, 6 * 65536);
               d = floor_divide(e * longint'(plan_discount), 65536);
               tot = longint'(plan_reward) + d;
               if (tot > 64'sh7FFFFFFF) tot = 64'sh7FFFFFFF;
               if (tot < -64'sh80000000) tot = -64'sh80000000;
               if (n == 0 || tot > best) begin
                  best = tot;
                  ans.action = 3'(n);
               end
            end
            ans.value = 32'(best);
            ans.updated = 1'b1;
            write_next(a, ans.value);
         end
      end else if (cmd == gvi_pkg::CMD_SWAP) begin
         plan_bank_sel = ~plan_bank_sel;
      end
      return ans;
   endfunction

   task automatic sender_gap();
      if (idling_enabled && $urandom_range(0, 5) == 0)
         repeat ($urandom_range(1, 11)) @(posedge clock);
   endtask

   task automatic send_item(input logic [1:0] cmd, input int r, input int t, input int p,
         input logic [31:0] value, input logic obs, input logic goal);
      sender_gap();
      start <= 1'b1;
      req_command <= cmd;
      req_r_index <= 4'(r);
      req_theta_index <= 4'(t);
      req_phi_index <= 4'(p);
      req_cell_value <= value;
      req_is_obstacle <= obs;
      req_is_goal <= goal;
      @(posedge clock);
      while (busy) @(posedge clock);
      answer_queue.push_back(iterate_cell(cmd, r, t, p, value, obs, goal));
      sent_count++;
      if (cmd == gvi_pkg::CMD_UPDATE) update_count++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      @(posedge clock);
      while (answer_queue.size() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == gvi_pkg::REG_MOVE_REWARD) plan_reward = data;
      else if (index == gvi_pkg::REG_DISCOUNT) plan_discount = data[15:0];
      else if (index == gvi_pkg::REG_ERROR_PROB) plan_error_prob = data[15:0];
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] reward, input logic [15:0] disc,
         input logic [15:0] prob);
      wait_drained();
      write_register(gvi_pkg::REG_MOVE_REWARD, reward);
      write_register(gvi_pkg::REG_DISCOUNT, {16'd0, disc});
      write_register(gvi_pkg::REG_ERROR_PROB, {16'd0, prob});
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom;
      endcase
   endfunction

   task automatic fill_block(input int r0, input int t0, input int p0, input int n);
      for (int r = r0; r < r0 + n; r++)
         for (int t = t0; t < t0 + n; t++)
            for (int p = p0; p < p0 + n; p++)
               send_item(gvi_pkg::CMD_WRITE, r % 16, t % 16, p % 16, random_value(),
                         $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
   endtask

   task automatic fill_line_neighbors(input int r, input int t, input int p);
      send_item(gvi_pkg::CMD_WRITE, r, t, p, random_value(), 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_WRITE, r < 15 ? r + 1 : r, t, p, random_value(), 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_WRITE, r > 0 ? r - 1 : r, t, p, random_value(), 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_WRITE, r, (t + 1) % 16, p, random_value(), 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_WRITE, r, (t + 15) % 16, p, random_value(), 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_WRITE, r, t, (p + 1) % 16, random_value(), 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_WRITE, r, t, (p + 15) % 16, random_value(), 1'b0, 1'b0);
   endtask

   function automatic bit neighbors_written(input int r, input int t, input int p);
      return plan_written[cell_index(r, t, p)]
          && plan_written[cell_index(r < 15 ? r + 1 : r, t, p)]
          && plan_written[cell_index(r > 0 ? r - 1 : r, t, p)]
          && plan_written[cell_index(r, (t + 1) % 16, p)]
          && plan_written[cell_index(r, (t + 15) % 16, p)]
          && plan_written[cell_index(r, t, (p + 1) % 16)]
          && plan_written[cell_index(r, t, (p + 15) % 16)];
   endfunction

   task automatic test_grid_edges();
      fill_line_neighbors(0, 0, 0);
      send_item(gvi_pkg::CMD_UPDATE, 0, 0, 0, 32'h0, 1'b0, 1'b0);
      fill_line_neighbors(15, 15, 15);
      send_item(gvi_pkg::CMD_UPDATE, 15, 15, 15, 32'hFFFFFFFF, 1'b1, 1'b1);
      send_item(gvi_pkg::CMD_SWAP, 0, 0, 0, 32'h0, 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_UPDATE, 15, 15, 15, 32'h0, 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_UNUSED, 7, 7, 7, 32'h0, 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_WRITE, 0, 0, 0, 32'h7FFFFFFF, 1'b1, 1'b0);
      send_item(gvi_pkg::CMD_UPDATE, 0, 0, 0, 32'h0, 1'b0, 1'b0);
      send_item(gvi_pkg::CMD_WRITE, 0, 0, 0, 32'h80000000, 1'b0, 1'b1);
      send_item(gvi_pkg::CMD_UPDATE, 0, 0, 0, 32'h0, 1'b0, 1'b0);
   endtask

   task automatic test_saturation();
      configure(32'h7FFFFFFF, 16'hFFFF, 16'hFFFF);
      fill_line_neighbors(8, 3, 9);
      send_item(gvi_pkg::CMD_UPDATE, 8, 3, 9, 32'h0, 1'b0, 1'b0);
      configure(32'h80000000, 16'h0000, 16'h0000);
      send_item(gvi_pkg::CMD_UPDATE, 8, 3, 9, 32'h0, 1'b0, 1'b0);
      configure(32'h0, 16'hFFFF, 16'h0);
   endtask

   task automatic test_random_sweeps(input int rounds);
      int r, t, p;
      for (int k = 0; k < rounds; k++) begin
         if (k % 8 == 0)
            configure($urandom_range(0, 3) == 0 ? random_value()
                         : 32'(signed'($urandom_range(0, 131072)) - 65536),
                      16'($urandom), 16'($urandom));
         r = $urandom_range(0, 12);
         t = $urandom_range(0, 15);
         p = $urandom_range(0, 15);
         fill_block(r, t, p, 3);
         for (int u = 0; u < 10; u++) begin
            r = $urandom_range(0, 15);
            t = $urandom_range(0, 15);
            p = $urandom_range(0, 15);
            if ($urandom_range(0, 9) == 0)
               send_item(gvi_pkg::CMD_SWAP, r, t, p, $urandom, 1'($urandom), 1'($urandom));
            else if ($urandom_range(0, 19) == 0)
               send_item(gvi_pkg::CMD_UNUSED, r, t, p, $urandom, 1'($urandom),
                         1'($urandom));
            else if (neighbors_written(r, t, p))
               send_item(gvi_pkg::CMD_UPDATE, r, t, p, $urandom, 1'($urandom),
                         1'($urandom));
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (answer_queue.size() == 0) begin
            $display("%0t: unexpected result value %h action %0d updated %0d", $time,
                     rsp_new_value, rsp_best_action, rsp_updated);
            error_count++;
         end else begin
            cell_answer_type exp_ans;
            exp_ans = answer_queue.pop_front();
            if (rsp_new_value !== exp_ans.value) begin
               $display("%0t: new_value expected %h actual %h", $time, exp_ans.value,
                        rsp_new_value);
               error_count++;
            end
            if (rsp_best_action !== exp_ans.action) begin
               $display("%0t: best_action expected %0d actual %0d", $time,
                        exp_ans.action, rsp_best_action);
               error_count++;
            end
            if (rsp_updated !== exp_ans.updated) begin
               $display("%0t: updated expected %0d actual %0d", $time, exp_ans.updated,
                        rsp_updated);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("grid_value_iteration_cell: mismatch");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_command = gvi_pkg::CMD_WRITE;
      req_r_index = '0;
      req_theta_index = '0;
      req_phi_index = '0;
      req_cell_value = '0;
      req_is_obstacle = 1'b0;
      req_is_goal = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = gvi_pkg::REG_MOVE_REWARD;
      csr_write_data = '0;
      sent_count = 0;
      update_count = 0;
      idling_enabled = 1'b1;
      plan_bank_sel = 1'b0;
      plan_reward = 0;
      plan_discount = 16'hFFFF;
      plan_error_prob = 16'h0;
      foreach (plan_written[i]) begin
         plan_written[i] = 1'b0;
         plan_obstacle[i] = 1'b0;
         plan_goal[i] = 1'b0;
         plan_bank_a[i] = '0;
         plan_bank_b[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_grid_edges();
      test_saturation();
      test_random_sweeps(42);
      idling_enabled = 1'b0;
      test_random_sweeps(8);
      wait_drained();
      $display("Covered %0d transactions, %0d of them updates, over edge, wrap, swap,",
               sent_count, update_count);
      $display("obstacle, goal and saturating register settings.");
      if (error_count == 0 && answer_queue.size() == 0) begin
         $display("grid_value_iteration_cell: match");
      end else begin
         $display("grid_value_iteration_cell: mismatch");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/gvi_pkg.sv
design/gvi_ram.sv
design/gvi_action_pipe.sv
design/grid_value_iteration_cell.sv
sim/tb_grid_value_iteration_cell.sv
